// ===== rtl/core/efo_pkg.sv =====
// ----------------------------------------------------------------------------
// efo_pkg
// Shared types and constants for the event queue with overflow policy.
// ----------------------------------------------------------------------------
package efo_pkg;

    localparam int DEPTH     = 256;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EVENT_W   = 32;
    localparam int CNT_W     = 9;
    localparam int DROP_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 9;
    localparam int IN_W      = 32;
    localparam int OUT_W     = 80;

    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 1'b1;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_SPACE  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD
    } efo_state_t;

    typedef struct packed {
        logic latch;
        logic exec;
        logic load;
    } efo_cmd_t;

    typedef struct packed {
        logic out_free;
    } efo_stat_t;

endpackage

// ===== rtl/core/efo_ram.sv =====
// ----------------------------------------------------------------------------
// efo_ram
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module efo_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/efo_ctrl.sv =====
// ----------------------------------------------------------------------------
// efo_ctrl
// Sequencer: accept a word, execute it against the queue, load the result.
// ----------------------------------------------------------------------------
module efo_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  efo_pkg::efo_stat_t stat,
    output efo_pkg::efo_cmd_t  cmd
);
    import efo_pkg::*;

    efo_state_t state_reg;
    efo_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                // wait here until the output register can take the result
                if (stat.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/efo_dp.sv =====
// ----------------------------------------------------------------------------
// efo_dp
// Queue datapath: pointers, count, drop counter, entry store, result register.
// ----------------------------------------------------------------------------
module efo_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  efo_pkg::efo_cmd_t               cmd,
    output efo_pkg::efo_stat_t              stat,
    input  logic                            in_cmd,
    input  logic [efo_pkg::EVENT_W-1:0]     in_data,
    input  logic                            cfg_we,
    input  logic [efo_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [efo_pkg::CFG_W-1:0]       cfg_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [efo_pkg::STATUS_W-1:0]    out_status,
    output logic [efo_pkg::EVENT_W-1:0]     out_event,
    output logic [efo_pkg::CNT_W-1:0]       out_count,
    output logic [efo_pkg::DROP_W-1:0]      out_drops
);
    import efo_pkg::*;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    function automatic logic [ADDR_W-1:0] advance(input logic [ADDR_W-1:0] p,
                                                  input logic [CNT_W-1:0]  cap);
        logic [CNT_W-1:0] p1;
        p1 = CNT_W'(p) + CNT_W'(1);
        if (p1 >= cap)
        begin
            return '0;
        end
        return p1[ADDR_W-1:0];
    endfunction

    // configuration
    logic [CNT_W-1:0]    cap_reg;
    logic                mode_reg;
    logic [CNT_W-1:0]    cap_clamped;

    // queue state
    logic [ADDR_W-1:0]   rd_ptr_reg;
    logic [ADDR_W-1:0]   wr_ptr_reg;
    logic [CNT_W-1:0]    held_reg;
    logic [DROP_W-1:0]   drop_reg;

    // latched item and execute outcome
    logic                cmd_reg;
    logic [EVENT_W-1:0]  data_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic                got_reg;
    logic                got_next;

    // result register
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [EVENT_W-1:0]  out_event_reg;
    logic [CNT_W-1:0]    out_count_reg;
    logic [DROP_W-1:0]   out_drops_reg;

    logic [ADDR_W-1:0]   rd_ptr_next;
    logic [ADDR_W-1:0]   wr_ptr_next;
    logic [CNT_W-1:0]    held_next;
    logic [DROP_W-1:0]   drop_next;
    logic                ram_we;
    logic                ram_re;
    logic [EVENT_W-1:0]  ram_rdata;
    logic                full;

    always_comb
    begin
        priority if (cfg_data == '0)
        begin
            cap_clamped = CNT_W'(1);
        end
        else if (cfg_data > DEPTH_CNT)
        begin
            cap_clamped = DEPTH_CNT;
        end
        else
        begin
            cap_clamped = cfg_data;
        end
    end

    assign full = (held_reg >= cap_reg);

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        held_next   = held_reg;
        drop_next   = drop_reg;
        status_next = STATUS_OK;
        got_next    = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        if (cmd.exec)
        begin
            unique case (cmd_reg)
                CMD_PUSH:
                begin
                    if (full)
                    begin
                        drop_next = drop_reg + DROP_W'(1);
                        if (mode_reg)
                        begin
                            // overwrite: oldest goes, newest comes, count stays
                            rd_ptr_next = advance(rd_ptr_reg, cap_reg);
                            wr_ptr_next = advance(wr_ptr_reg, cap_reg);
                            ram_we      = 1'b1;
                        end
                        else
                        begin
                            status_next = STATUS_NO_SPACE;
                        end
                    end
                    else
                    begin
                        wr_ptr_next = advance(wr_ptr_reg, cap_reg);
                        held_next   = held_reg + CNT_W'(1);
                        ram_we      = 1'b1;
                    end
                end
                CMD_POP:
                begin
                    if (held_reg == '0)
                    begin
                        status_next = STATUS_NOT_FOUND;
                    end
                    else
                    begin
                        ram_re      = 1'b1;
                        got_next    = 1'b1;
                        rd_ptr_next = advance(rd_ptr_reg, cap_reg);
                        held_next   = held_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    status_next = STATUS_OK;
                end
            endcase
        end
    end

    efo_ram #(
        .WIDTH (EVENT_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata (data_reg),
        .re    (ram_re),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg    <= DEPTH_CNT;
            mode_reg   <= 1'b0;
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            held_reg   <= '0;
            drop_reg   <= '0;
        end
        else
        begin
            priority if (cfg_we && (cfg_index == REG_CAPACITY))
            begin
                // new capacity empties the queue, drop total is kept
                cap_reg    <= cap_clamped;
                rd_ptr_reg <= '0;
                wr_ptr_reg <= '0;
                held_reg   <= '0;
            end
            else if (cfg_we && (cfg_index == REG_MODE))
            begin
                mode_reg <= cfg_data[0];
            end
            else
            begin
                rd_ptr_reg <= rd_ptr_next;
                wr_ptr_reg <= wr_ptr_next;
                held_reg   <= held_next;
                drop_reg   <= drop_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            cmd_reg  <= in_cmd;
            data_reg <= in_data;
        end
        if (cmd.exec)
        begin
            status_reg <= status_next;
            got_reg    <= got_next;
        end
        if (cmd.load)
        begin
            out_status_reg <= status_reg;
            out_event_reg  <= got_reg ? ram_rdata : '0;
            out_count_reg  <= held_reg;
            out_drops_reg  <= drop_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_status    = out_status_reg;
    assign out_event     = out_event_reg;
    assign out_count     = out_count_reg;
    assign out_drops     = out_drops_reg;

endmodule

// ===== rtl/core/event_fifo_with_overflow_policy_top.sv =====
// ----------------------------------------------------------------------------
// event_fifo_with_overflow_policy_top
// Circular event queue with drop-newest or drop-oldest overflow handling.
// ----------------------------------------------------------------------------
// Each input word is a push or a pop and yields exactly one result word. An
// item passes through accept, execute (queue update plus the store write or
// read on the memory's single write and single read port), then load into
// the output register; a new word is taken only once the previous one has
// been loaded, and a result held back by the output side stalls only the load
// step of the following item. Writing the capacity register empties the queue
// but keeps the drop total; capacity zero acts as one and values above the
// store depth act as the depth. The entry store needs no clearing after reset.
module event_fifo_with_overflow_policy_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [efo_pkg::IN_W-1:0]       s_tdata,   // event_data
    input  logic                           s_tuser,   // cmd
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [efo_pkg::OUT_W-1:0]      m_tdata,   // status, event_out, queue_count,
                                                      // dropped_total, zero pad
    input  logic                           cfg_we,
    input  logic [efo_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [efo_pkg::CFG_W-1:0]      cfg_data
);
    import efo_pkg::*;

    localparam int PAD_W = OUT_W - (STATUS_W + EVENT_W + CNT_W + DROP_W);

    efo_cmd_t            cmd;
    efo_stat_t           stat;
    logic [STATUS_W-1:0] out_status;
    logic [EVENT_W-1:0]  out_event;
    logic [CNT_W-1:0]    out_count;
    logic [DROP_W-1:0]   out_drops;

    efo_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    efo_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_cmd     (s_tuser),
        .in_data    (s_tdata[EVENT_W-1:0]),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_event  (out_event),
        .out_count  (out_count),
        .out_drops  (out_drops)
    );

    assign m_tdata = {{PAD_W{1'b0}}, out_drops, out_count, out_event, out_status};

endmodule
